FILE: hw/rtl/ookenc_pkg.sv
// shared types and constants for the ook remote code pulse encoder
`timescale 1ns / 1ps
`default_nettype none
package ookenc_pkg;

    // fixed field widths
    localparam int CODE_W   = 12;
    localparam int UNIT_W   = 16;
    localparam int GAP_W    = 24;
    localparam int REPEAT_W = 8;
    localparam int TICK_W   = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 2'd2;

    // configuration reset values
    localparam logic [UNIT_W-1:0]   UNIT_TICKS_RST   = 16'd350;
    localparam logic [GAP_W-1:0]    GAP_TICKS_RST    = 24'd100000;
    localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RST = 8'd4;

    // input beat commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit_ticks;
        logic [GAP_W-1:0]    gap_ticks;
        logic [REPEAT_W-1:0] repeat_count;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] code;
    } item_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic start_ignored;
        logic last_frame_done;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ookenc_item_if.sv
// input channel: start/tick commands with the code to send
`timescale 1ns / 1ps
`default_nettype none
interface ookenc_item_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [ookenc_pkg::CODE_W-1:0] code;

    modport source (output valid, output cmd, output code, input ready);
    modport sink   (input valid, input cmd, input code, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ookenc_result_if.sv
// output channel: pin level and status per beat
`timescale 1ns / 1ps
`default_nettype none
interface ookenc_result_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic start_ignored;
    logic last_frame_done;

    modport source (output valid, output pin_level, output busy_res,
                    output start_ignored, output last_frame_done, input ready);
    modport sink   (input valid, input pin_level, input busy_res,
                    input start_ignored, input last_frame_done, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ookenc_cfg.sv
// configuration register file
`timescale 1ns / 1ps
`default_nettype none
module ookenc_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ookenc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ookenc_pkg::CFG_W-1:0]      cfg_wdata,
    output ookenc_pkg::cfg_t                       cfg
);

    ookenc_pkg::cfg_t cfg_reg;
    ookenc_pkg::cfg_t cfg_next;

    // decode one register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ookenc_pkg::REG_UNIT_TICKS:
                    cfg_next.unit_ticks = cfg_wdata[ookenc_pkg::UNIT_W-1:0];
                ookenc_pkg::REG_GAP_TICKS:
                    cfg_next.gap_ticks = cfg_wdata[ookenc_pkg::GAP_W-1:0];
                ookenc_pkg::REG_REPEAT_COUNT:
                    cfg_next.repeat_count = cfg_wdata[ookenc_pkg::REPEAT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ticks   <= ookenc_pkg::UNIT_TICKS_RST;
            cfg_reg.gap_ticks    <= ookenc_pkg::GAP_TICKS_RST;
            cfg_reg.repeat_count <= ookenc_pkg::REPEAT_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ookenc_in_stage.sv
// input register stage for command beats
`timescale 1ns / 1ps
`default_nettype none
module ookenc_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire ookenc_pkg::item_t  up_item,
    output logic                    down_valid,
    input  wire logic               down_ready,
    output ookenc_pkg::item_t       down_item
);

    logic              valid_reg;
    logic              valid_next;
    ookenc_pkg::item_t item_reg;

    // take a new beat whenever the held one leaves or none is held
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= up_item;
    end

    assign down_valid = valid_reg;
    assign down_item  = item_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ookenc_core.sv
// frame sequencer: preamble, bit segments, gap and repeat count
`timescale 1ns / 1ps
`default_nettype none
module ookenc_core #(
    parameter int CODE_BITS = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ookenc_pkg::cfg_t   cfg,
    input  wire logic               fire,
    input  wire ookenc_pkg::item_t  item,
    output ookenc_pkg::result_t     result
);

    localparam int BI_W  = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam int EXT_W = (CODE_BITS > ookenc_pkg::CODE_W) ? CODE_BITS
                                                            : ookenc_pkg::CODE_W;
    localparam logic [BI_W-1:0] TOP_BIT = BI_W'(CODE_BITS - 1);
    localparam int SEG_W = 18;

    // phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PRE  = 2'd1;
    localparam logic [1:0] PH_BITS = 2'd2;
    localparam logic [1:0] PH_GAP  = 2'd3;
    localparam logic [1:0] SEG_LAST = 2'd3;

    logic [CODE_BITS-1:0]               code_bits_reg, code_bits_next;
    logic [1:0]                         phase_reg, phase_next;
    logic [BI_W-1:0]                    bit_index_reg, bit_index_next;
    logic [1:0]                         seg_index_reg, seg_index_next;
    logic                               seg_long_reg, seg_long_next;
    logic [ookenc_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [ookenc_pkg::REPEAT_W-1:0]    frames_reg, frames_next;
    logic                               pin_reg, pin_next;

    logic [EXT_W-1:0]                   code_ext;
    logic [ookenc_pkg::UNIT_W-1:0]      unit_len;
    logic [SEG_W-1:0]                   seg_dur;
    logic [ookenc_pkg::TICK_W-1:0]      dur;
    logic [ookenc_pkg::TICK_W-1:0]      tick_inc;
    logic [ookenc_pkg::REPEAT_W-1:0]    frames_dec;
    logic [BI_W-1:0]                    enter_index;
    logic [1:0]                         enter_seg;
    logic                               enter_bit;
    logic                               enter_en;
    logic                               frame_end;
    logic                               ignored;
    logic                               done;

    // code widened or trimmed to the configured width
    always_comb
    begin
        code_ext = '0;
        code_ext[ookenc_pkg::CODE_W-1:0] = item.code;
    end

    // current segment length in ticks
    assign unit_len = (cfg.unit_ticks == '0) ? ookenc_pkg::UNIT_W'(1) : cfg.unit_ticks;
    assign seg_dur  = seg_long_reg ? ({1'b0, unit_len, 1'b0} + SEG_W'(unit_len))
                                   : SEG_W'(unit_len);
    assign tick_inc   = tick_reg + ookenc_pkg::TICK_W'(1);
    assign frames_dec = frames_reg - ookenc_pkg::REPEAT_W'(1);

    always_comb
    begin
        case (phase_reg)
            PH_PRE:  dur = ookenc_pkg::TICK_W'(unit_len);
            PH_BITS: dur = ookenc_pkg::TICK_W'(seg_dur);
            default: dur = cfg.gap_ticks;
        endcase
    end

    // next state for one beat
    always_comb
    begin
        code_bits_next = code_bits_reg;
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        seg_index_next = seg_index_reg;
        seg_long_next  = seg_long_reg;
        tick_next      = tick_reg;
        frames_next    = frames_reg;
        pin_next       = pin_reg;
        ignored        = 1'b0;
        done           = 1'b0;
        enter_en       = 1'b0;
        enter_index    = bit_index_reg;
        enter_seg      = seg_index_reg;
        frame_end      = 1'b0;

        if (item.cmd == ookenc_pkg::CMD_START)
        begin
            if (phase_reg != PH_IDLE)
            begin
                ignored = 1'b1;
            end
            else
            begin
                code_bits_next = code_ext[CODE_BITS-1:0];
                frames_next    = (cfg.repeat_count == '0) ? ookenc_pkg::REPEAT_W'(1)
                                                          : cfg.repeat_count;
                bit_index_next = '0;
                seg_index_next = '0;
                seg_long_next  = 1'b0;
                phase_next     = PH_PRE;
                pin_next       = 1'b1;
                tick_next      = '0;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (tick_inc < dur)
            begin
                tick_next = tick_inc;
            end
            else
            begin
                case (phase_reg)
                    PH_PRE:
                    begin
                        phase_next     = PH_BITS;
                        bit_index_next = TOP_BIT;
                        seg_index_next = '0;
                        enter_en       = 1'b1;
                        enter_index    = TOP_BIT;
                        enter_seg      = '0;
                    end
                    PH_BITS:
                    begin
                        if (seg_index_reg != SEG_LAST)
                        begin
                            seg_index_next = seg_index_reg + 2'd1;
                            enter_en       = 1'b1;
                            enter_seg      = seg_index_reg + 2'd1;
                        end
                        else if (bit_index_reg != '0)
                        begin
                            bit_index_next = bit_index_reg - BI_W'(1);
                            seg_index_next = '0;
                            enter_en       = 1'b1;
                            enter_index    = bit_index_reg - BI_W'(1);
                            enter_seg      = '0;
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                            pin_next   = 1'b0;
                            tick_next  = '0;
                            frame_end  = (cfg.gap_ticks == '0);
                        end
                    end
                    default:
                    begin
                        frame_end = 1'b1;
                    end
                endcase
            end
        end

        // load a bit segment: length and pin level from segment position
        enter_bit = code_bits_reg[enter_index];
        if (enter_en)
        begin
            seg_long_next = enter_bit ? !enter_seg[0] : !enter_seg[1];
            pin_next      = enter_seg[0];
            tick_next     = '0;
        end

        // frame finished: repeat or go idle
        if (frame_end)
        begin
            frames_next = frames_dec;
            tick_next   = '0;
            if (frames_dec == '0)
            begin
                phase_next = PH_IDLE;
                pin_next   = 1'b0;
                done       = 1'b1;
            end
            else
            begin
                phase_next = PH_PRE;
                pin_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg <= '0;
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
            seg_index_reg <= '0;
            seg_long_reg  <= 1'b0;
            tick_reg      <= '0;
            frames_reg    <= '0;
            pin_reg       <= 1'b0;
        end
        else if (fire)
        begin
            code_bits_reg <= code_bits_next;
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            seg_index_reg <= seg_index_next;
            seg_long_reg  <= seg_long_next;
            tick_reg      <= tick_next;
            frames_reg    <= frames_next;
            pin_reg       <= pin_next;
        end
    end

    // result of this beat
    assign result.pin_level       = pin_next;
    assign result.busy_res        = (phase_next != PH_IDLE);
    assign result.start_ignored   = ignored;
    assign result.last_frame_done = done;

endmodule
`default_nettype wire

FILE: hw/rtl/ookenc_out_stage.sv
// result register with backpressure
`timescale 1ns / 1ps
`default_nettype none
module ookenc_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire ookenc_pkg::result_t  up_result,
    output logic                      down_valid,
    input  wire logic                 down_ready,
    output ookenc_pkg::result_t       down_result
);

    logic                valid_reg;
    logic                valid_next;
    ookenc_pkg::result_t result_reg;

    // load when empty or when the held beat is taken
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            result_reg <= up_result;
    end

    assign down_valid  = valid_reg;
    assign down_result = result_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ook_remote_code_pulse_encoder_unit.sv
// A beat is held in the input register, and its result then in the result register.
// Throughput: one beat per cycle unless the result side stalls; each beat gives one result.
// The rate is set by the single-pass frame sequencer between the input and result registers.
// Reset: rst_n async low; sequencer idle with pin low, config back to 350/100000/4.
// top level of the ook remote code pulse encoder
`timescale 1ns / 1ps
`default_nettype none
module ook_remote_code_pulse_encoder_unit #(
    parameter int CODE_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ookenc_item_if.sink                            item,
    ookenc_result_if.source                        result,
    input  wire logic                              cfg_we,
    input  wire logic [ookenc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ookenc_pkg::CFG_W-1:0]      cfg_wdata
);

    ookenc_pkg::cfg_t    cfg;
    ookenc_pkg::item_t   in_item;
    ookenc_pkg::item_t   s1_item;
    ookenc_pkg::result_t core_result;
    ookenc_pkg::result_t out_result;
    logic                s1_valid;
    logic                out_up_ready;
    logic                fire;

    assign in_item.cmd  = item.cmd;
    assign in_item.code = item.code;

    ookenc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ookenc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (item.valid),
        .up_ready   (item.ready),
        .up_item    (in_item),
        .down_valid (s1_valid),
        .down_ready (out_up_ready),
        .down_item  (s1_item)
    );

    // state advances when the held beat moves into the result register
    assign fire = s1_valid && out_up_ready;

    ookenc_core #(
        .CODE_BITS (CODE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (s1_item),
        .result (core_result)
    );

    ookenc_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (s1_valid),
        .up_ready    (out_up_ready),
        .up_result   (core_result),
        .down_valid  (result.valid),
        .down_ready  (result.ready),
        .down_result (out_result)
    );

    assign result.pin_level       = out_result.pin_level;
    assign result.busy_res        = out_result.busy_res;
    assign result.start_ignored   = out_result.start_ignored;
    assign result.last_frame_done = out_result.last_frame_done;

endmodule
`default_nettype wire

FILE: test/ook_remote_code_pulse_encoder_unit_tb.sv
// testbench for the ook remote code pulse encoder: directed table, random frames, beat checks
`timescale 1ns / 1ps
module ook_remote_code_pulse_encoder_unit_tb;
    import ookenc_pkg::*;

    localparam int RANDOM_BEATS   = 300;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    // segment lengths in units, segment 0 in the low two bits
    localparam logic [7:0] ONE_UNITS  = {2'd1, 2'd3, 2'd1, 2'd3};
    localparam logic [7:0] ZERO_UNITS = {2'd1, 2'd1, 2'd3, 2'd3};

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_PRE, SEQ_BITS, SEQ_GAP} seq_phase_e;
    typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_DRAIN} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      val;
        logic                  cmd;
        logic [CODE_W-1:0]     code;
        int                    count;
        bit                    typed;
        result_t               res;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    ookenc_item_if   item_ch ();
    ookenc_result_if res_ch ();

    ook_remote_code_pulse_encoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // pulse sequencer mirror
    logic [UNIT_W-1:0]   mdl_unit;
    logic [GAP_W-1:0]    mdl_gap;
    logic [REPEAT_W-1:0] mdl_repeat;
    logic [CODE_W-1:0]   mdl_code;
    seq_phase_e          mdl_phase;
    logic [3:0]          mdl_bit;
    logic [1:0]          mdl_seg;
    logic [1:0]          mdl_seg_units;
    logic [TICK_W-1:0]   mdl_ticks;
    logic [7:0]          mdl_frames;
    logic                mdl_pin;

    result_t   pending_results[$];
    stim_row_t dir_rows[$];
    int        errors = 0;
    int        beats_sent = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // load one bit segment: level and length
    function automatic void enter_segment();
        logic b;
        b = mdl_code[mdl_bit];
        mdl_seg_units = b ? ONE_UNITS[2*mdl_seg +: 2] : ZERO_UNITS[2*mdl_seg +: 2];
        mdl_pin = mdl_seg[0];
        mdl_ticks = '0;
    endfunction

    function automatic void open_frame();
        mdl_phase = SEQ_PRE;
        mdl_pin = 1'b1;
        mdl_ticks = '0;
    endfunction

    // one frame finished; high when it was the last one
    function automatic logic close_frame();
        mdl_frames = mdl_frames - 8'd1;
        if (mdl_frames == 8'd0)
        begin
            mdl_phase = SEQ_IDLE;
            mdl_pin = 1'b0;
            mdl_ticks = '0;
            return 1'b1;
        end
        open_frame();
        return 1'b0;
    endfunction

    function automatic logic advance_tick();
        int unsigned ulen;
        int unsigned dur;
        if (mdl_phase == SEQ_IDLE)
            return 1'b0;
        ulen = (mdl_unit == '0) ? 1 : mdl_unit;
        mdl_ticks = mdl_ticks + 1'b1;
        if (mdl_phase == SEQ_PRE)
            dur = ulen;
        else if (mdl_phase == SEQ_BITS)
            dur = mdl_seg_units * ulen;
        else
            dur = mdl_gap;
        if (mdl_ticks < dur)
            return 1'b0;
        if (mdl_phase == SEQ_PRE)
        begin
            mdl_phase = SEQ_BITS;
            mdl_bit = CODE_W - 1;
            mdl_seg = 2'd0;
            enter_segment();
            return 1'b0;
        end
        if (mdl_phase == SEQ_BITS)
        begin
            if (mdl_seg < 2'd3)
            begin
                mdl_seg = mdl_seg + 2'd1;
                enter_segment();
                return 1'b0;
            end
            if (mdl_bit > 4'd0)
            begin
                mdl_bit = mdl_bit - 4'd1;
                mdl_seg = 2'd0;
                enter_segment();
                return 1'b0;
            end
            mdl_phase = SEQ_GAP;
            mdl_pin = 1'b0;
            mdl_ticks = '0;
            if (mdl_gap == '0)
                return close_frame();
            return 1'b0;
        end
        return close_frame();
    endfunction

    function automatic result_t predict_pulse(logic c, logic [CODE_W-1:0] code);
        result_t r;
        r.start_ignored   = 1'b0;
        r.last_frame_done = 1'b0;
        if (c == CMD_START)
        begin
            if (mdl_phase != SEQ_IDLE)
                r.start_ignored = 1'b1;
            else
            begin
                mdl_code = code;
                mdl_frames = (mdl_repeat == '0) ? 8'd1 : mdl_repeat;
                mdl_bit = 4'd0;
                mdl_seg = 2'd0;
                mdl_seg_units = 2'd0;
                open_frame();
            end
        end
        else
            r.last_frame_done = advance_tick();
        r.pin_level = mdl_pin;
        r.busy_res  = (mdl_phase != SEQ_IDLE);
        return r;
    endfunction

    // send one beat after a random gap, then queue what it should give
    task automatic drive_beat(logic c, logic [CODE_W-1:0] code, bit typed, result_t typed_res);
        int gap;
        result_t pred;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd   <= c;
        item_ch.code  <= code;
        do @(posedge clk); while (!item_ch.ready);
        pred = predict_pulse(c, code);
        pending_results.push_back(typed ? typed_res : pred);
        beats_sent++;
    endtask

    task automatic drive_random_beat(logic c);
        drive_beat(c, CODE_W'($urandom), 1'b0, '0);
    endtask

    // register write, only once every result is back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_UNIT_TICKS:   mdl_unit   = val[UNIT_W-1:0];
            REG_GAP_TICKS:    mdl_gap    = val[GAP_W-1:0];
            REG_REPEAT_COUNT: mdl_repeat = val[REPEAT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain_frames();
        while (mdl_phase != SEQ_IDLE)
            drive_beat(CMD_TICK, '0, 1'b0, '0);
    endtask

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        stim_row_t r;
        r = '{kind: ROW_CFG, idx: idx, val: val, cmd: CMD_TICK, code: '0,
              count: 0, typed: 1'b0, res: '0};
        return r;
    endfunction

    function automatic stim_row_t beat_row(logic c, logic [CODE_W-1:0] code, int count,
                                           bit typed, result_t res);
        stim_row_t r;
        r = '{kind: ROW_BEAT, idx: '0, val: '0, cmd: c, code: code,
              count: count, typed: typed, res: res};
        return r;
    endfunction

    function automatic stim_row_t drain_row();
        stim_row_t r;
        r = '{kind: ROW_DRAIN, idx: '0, val: '0, cmd: CMD_TICK, code: '0,
              count: 0, typed: 1'b0, res: '0};
        return r;
    endfunction

    // result side: random back-pressure
    initial
    begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!quiet)
                    stall = pick_gap();
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.pin_level       = res_ch.pin_level;
            got.busy_res        = res_ch.busy_res;
            got.start_ignored   = res_ch.start_ignored;
            got.last_frame_done = res_ch.last_frame_done;
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (got.pin_level !== want.pin_level)
                    report_mismatch($sformatf("pin_level got %b want %b",
                                              got.pin_level, want.pin_level));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res got %b want %b",
                                              got.busy_res, want.busy_res));
                if (got.start_ignored !== want.start_ignored)
                    report_mismatch($sformatf("start_ignored got %b want %b",
                                              got.start_ignored, want.start_ignored));
                if (got.last_frame_done !== want.last_frame_done)
                    report_mismatch($sformatf("last_frame_done got %b want %b",
                                              got.last_frame_done, want.last_frame_done));
            end
        end
    end

    // watchdog on cycles without any beat or write
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int rand_start;
        int r;
        logic [CFG_W-1:0] unit_v;
        logic [CFG_W-1:0] gap_v;
        logic [CFG_W-1:0] rep_v;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        item_ch.valid <= 1'b0;
        item_ch.cmd   <= CMD_TICK;
        item_ch.code  <= '0;

        mdl_unit      = UNIT_TICKS_RST;
        mdl_gap       = GAP_TICKS_RST;
        mdl_repeat    = REPEAT_COUNT_RST;
        mdl_code      = '0;
        mdl_phase     = SEQ_IDLE;
        mdl_bit       = '0;
        mdl_seg       = '0;
        mdl_seg_units = '0;
        mdl_ticks     = '0;
        mdl_frames    = '0;
        mdl_pin       = 1'b0;

        // directed table; typed results read as {pin, busy, ignored, done}
        // idle ticks after reset keep the pin low
        dir_rows.push_back(beat_row(CMD_TICK, 12'hFFF, 3, 1'b1, 4'b0000));
        // zero unit and zero repeat act as one, zero gap ends frame on last bit
        dir_rows.push_back(cfg_row(REG_UNIT_TICKS, 24'd0));
        dir_rows.push_back(cfg_row(REG_GAP_TICKS, 24'd0));
        dir_rows.push_back(cfg_row(REG_REPEAT_COUNT, 24'd0));
        dir_rows.push_back(beat_row(CMD_START, 12'hFFF, 1, 1'b1, 4'b1100));
        // start while busy is flagged and does not advance time
        dir_rows.push_back(beat_row(CMD_START, 12'h000, 1, 1'b1, 4'b1110));
        dir_rows.push_back(drain_row());
        dir_rows.push_back(beat_row(CMD_TICK, 12'h000, 2, 1'b1, 4'b0000));
        // two frames of all zeros with a short gap
        dir_rows.push_back(cfg_row(REG_UNIT_TICKS, 24'd1));
        dir_rows.push_back(cfg_row(REG_GAP_TICKS, 24'd5));
        dir_rows.push_back(cfg_row(REG_REPEAT_COUNT, 24'd2));
        dir_rows.push_back(beat_row(CMD_START, 12'h000, 1, 1'b0, '0));
        dir_rows.push_back(beat_row(CMD_START, 12'h5A5, 1, 1'b1, 4'b1110));
        dir_rows.push_back(drain_row());
        // one-tick gap, mixed code
        dir_rows.push_back(cfg_row(REG_UNIT_TICKS, 24'd2));
        dir_rows.push_back(cfg_row(REG_GAP_TICKS, 24'd1));
        dir_rows.push_back(cfg_row(REG_REPEAT_COUNT, 24'd1));
        dir_rows.push_back(beat_row(CMD_START, 12'hA5C, 1, 1'b0, '0));
        dir_rows.push_back(drain_row());
        // several repeats, back-to-back frames
        dir_rows.push_back(cfg_row(REG_REPEAT_COUNT, 24'd3));
        dir_rows.push_back(cfg_row(REG_UNIT_TICKS, 24'd1));
        dir_rows.push_back(cfg_row(REG_GAP_TICKS, 24'd0));
        dir_rows.push_back(beat_row(CMD_START, 12'h800, 1, 1'b0, '0));
        dir_rows.push_back(drain_row());
        // largest unit and gap, held while idle
        dir_rows.push_back(cfg_row(REG_UNIT_TICKS, 24'hFFFF));
        dir_rows.push_back(cfg_row(REG_GAP_TICKS, 24'hFFFFFF));
        dir_rows.push_back(beat_row(CMD_TICK, 12'h7FF, 3, 1'b1, 4'b0000));
        // longer unit, then a start right after the final frame
        dir_rows.push_back(cfg_row(REG_UNIT_TICKS, 24'd3));
        dir_rows.push_back(cfg_row(REG_GAP_TICKS, 24'd8));
        dir_rows.push_back(cfg_row(REG_REPEAT_COUNT, 24'd1));
        dir_rows.push_back(beat_row(CMD_START, 12'h7FF, 1, 1'b1, 4'b1100));
        dir_rows.push_back(drain_row());
        dir_rows.push_back(beat_row(CMD_START, 12'h001, 1, 1'b1, 4'b1100));
        dir_rows.push_back(drain_row());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_CFG:   write_reg(dir_rows[i].idx, dir_rows[i].val);
                ROW_BEAT:
                    repeat (dir_rows[i].count)
                        drive_beat(dir_rows[i].cmd, dir_rows[i].code,
                                   dir_rows[i].typed, dir_rows[i].res);
                ROW_DRAIN: drain_frames();
                default: ;
            endcase
        end

        // random settings, each followed by a few whole transmissions
        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                unit_v = 24'd0;
            else if (r < 75)
                unit_v = 24'd1;
            else if (r < 92)
                unit_v = $urandom_range(2, 3);
            else
                unit_v = $urandom_range(4, 6);
            r = $urandom_range(0, 99);
            if (r < 15)
                gap_v = 24'd0;
            else if (r < 85)
                gap_v = $urandom_range(1, 24);
            else
                gap_v = $urandom_range(30, 100);
            r = $urandom_range(0, 99);
            if (r < 10)
                rep_v = 24'd0;
            else if (r < 70)
                rep_v = 24'd1;
            else if (r < 95)
                rep_v = $urandom_range(2, 3);
            else
                rep_v = $urandom_range(4, 8);
            write_reg(REG_UNIT_TICKS, unit_v);
            write_reg(REG_GAP_TICKS, gap_v);
            write_reg(REG_REPEAT_COUNT, rep_v);
            quiet = ($urandom_range(0, 4) == 0);

            repeat ($urandom_range(1, 3))
            begin
                // idle noise, then a start with random code
                repeat ($urandom_range(0, 3))
                    drive_random_beat(CMD_TICK);
                drive_random_beat(CMD_START);
                while (mdl_phase != SEQ_IDLE)
                begin
                    if ($urandom_range(0, 99) < 3)
                        drive_random_beat(CMD_START);
                    else
                        drive_random_beat(CMD_TICK);
                end
            end
        end

        // wait for the last results, then settle
        item_ch.valid <= 1'b0;
        quiet = 1'b1;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ookenc_pkg.sv
hw/rtl/ookenc_item_if.sv
hw/rtl/ookenc_result_if.sv
hw/rtl/ookenc_cfg.sv
hw/rtl/ookenc_in_stage.sv
hw/rtl/ookenc_core.sv
hw/rtl/ookenc_out_stage.sv
hw/rtl/ook_remote_code_pulse_encoder_unit.sv
test/ook_remote_code_pulse_encoder_unit_tb.sv
